>>> rtl/wed_pkg.sv
// Shared types, constants and the substitution cost function for the weighted edit distance block.
package wed_pkg;

  localparam int unsigned SYM_W  = 8;
  localparam int unsigned DIST_W = 11;
  localparam int unsigned COST_W = 5;

  // Border step of the score table and the gap cost inside it, in tenths.
  localparam logic [COST_W-1:0] STEP_EDGE  = 5'd10;
  localparam logic [COST_W-1:0] COST_GAP   = 5'd5;
  localparam logic [COST_W-1:0] COST_NEAR  = 5'd2;
  localparam logic [COST_W-1:0] COST_FAR   = 5'd20;
  localparam logic [COST_W-1:0] COST_OTHER = 5'd5;

  localparam logic [SYM_W-1:0] SYM_ONE   = 8'h31;
  localparam logic [SYM_W-1:0] SYM_SIX   = 8'h36;
  localparam logic [SYM_W-1:0] SYM_SEVEN = 8'h37;
  localparam logic [SYM_W-1:0] SYM_EIGHT = 8'h38;

  localparam logic [2:0] RING_FIRST = 3'd0;
  localparam logic [2:0] RING_LAST  = 3'd5;

  typedef enum logic [1:0] {
    OP_APPEND_FIRST  = 2'd0,
    OP_APPEND_SECOND = 2'd1,
    OP_COMPUTE       = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INIT,
    ST_ROW,
    ST_CELL
  } state_e;

  typedef struct packed {
    logic [1:0]       operation;
    logic [SYM_W-1:0] symbol;
  } wed_in_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              overflow;
  } wed_out_t;

  // Cost of replacing c1 (first string) by c2 (second string), c1 != c2.
  function automatic logic [COST_W-1:0] sub_cost(input logic [SYM_W-1:0] c1,
                                                  input logic [SYM_W-1:0] c2);
    logic [2:0]       k;
    logic [2:0]       prev_k;
    logic [2:0]       next_k;
    logic [SYM_W-1:0] nb_prev;
    logic [SYM_W-1:0] nb_next;
    logic [COST_W-1:0] cost;
    k       = 3'(c1 - SYM_ONE);
    prev_k  = (k == RING_FIRST) ? RING_LAST : 3'(k - 3'd1);
    next_k  = (k == RING_LAST) ? RING_FIRST : 3'(k + 3'd1);
    nb_prev = SYM_ONE + SYM_W'(prev_k);
    nb_next = SYM_ONE + SYM_W'(next_k);
    if (c1 < SYM_ONE || c1 > SYM_SIX) begin
      cost = COST_OTHER;
    end else if (c2 == SYM_SEVEN || c2 == SYM_EIGHT || c2 == nb_prev || c2 == nb_next) begin
      cost = COST_NEAR;
    end else begin
      cost = COST_FAR;
    end
    return cost;
  endfunction

endpackage

>>> rtl/wed_ram.sv
// Generic single-write, single-read RAM with registered read data.
module wed_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                         clk_i,
  input  logic                                         we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                             wdata_i,
  input  logic                                         re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                             rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/weighted_edit_distance.sv
// Top level of the weighted edit distance block: string stores, score row and control.
//
// Append requests (operation 0 or 1) and unused operation codes are handled without
// leaving ST_IDLE; a symbol past MAX_LEN is dropped and sets the overflow flag. A compute
// request fills the first score row in ST_INIT, then walks the table row by row, one cell
// per cycle through the score-row memory with a setup step in ST_ROW before each row;
// it then emits the result and clears both strings and the overflow flag. The result
// waits in an output register, and the next request is taken once that register is free
// or drained.
module weighted_edit_distance
  import wed_pkg::*;
#(
  parameter int unsigned MAX_LEN = 64
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  wed_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output wed_out_t out_data_o
);

  localparam int unsigned AW     = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned LW     = $clog2(MAX_LEN + 1);
  localparam int unsigned SW_MIN = $clog2(15 * MAX_LEN + 1);
  localparam int unsigned SW     = (SW_MIN > DIST_W) ? SW_MIN : DIST_W;

  state_e state_q, state_d;

  logic [LW-1:0] len1_q, len1_d;
  logic [LW-1:0] len2_q, len2_d;
  logic          trunc_q, trunc_d;
  logic [AW-1:0] cidx_q, cidx_d;
  logic [AW-1:0] xidx_q, xidx_d;
  logic [SW-1:0] left_q, left_d;
  logic [SW-1:0] diag_q, diag_d;
  logic [SW-1:0] col_q, col_d;
  logic [SW-1:0] res_q, res_d;
  logic          out_valid_q, out_valid_d;
  wed_out_t      out_q, out_d;

  logic in_fire;
  logic full1, full2;
  logic init_last, cell_last, row_last, len1_zero;
  logic finish;

  logic             t1_we, t2_we, sc_we, row_re, t2_re;
  logic [AW-1:0]    row_raddr, sc_waddr;
  logic [SW-1:0]    sc_wdata;
  logic [SYM_W-1:0] c1, c2;
  logic [SW-1:0]    up;

  logic [SW:0]   up_sum, left_sum, diag_sum, min_ab, min_all;
  logic [SW-1:0] cell_v;
  logic [SW-1:0] col_next;

  assign in_ready_o = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign in_fire    = in_valid_i && in_ready_o;

  assign full1     = (len1_q == LW'(MAX_LEN));
  assign full2     = (len2_q == LW'(MAX_LEN));
  assign len1_zero = (len1_q == '0);
  assign init_last = len1_zero || (LW'(cidx_q) + LW'(1) == len1_q);
  assign cell_last = (LW'(cidx_q) + LW'(1) == len1_q);
  assign row_last  = (LW'(xidx_q) + LW'(1) == len2_q);
  assign col_next  = col_q + SW'(STEP_EDGE);

  // Score of one cell from its upper, left and diagonal neighbors.
  assign up_sum   = {1'b0, up} + (SW + 1)'(COST_GAP);
  assign left_sum = {1'b0, left_q} + (SW + 1)'(COST_GAP);
  assign diag_sum = {1'b0, diag_q} + (SW + 1)'(sub_cost(c1, c2));
  assign min_ab   = (up_sum < left_sum) ? up_sum : left_sum;
  assign min_all  = (min_ab < diag_sum) ? min_ab : diag_sum;
  assign cell_v   = (c1 == c2) ? diag_q : min_all[SW-1:0];

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire && in_data_i.operation == OP_COMPUTE) begin
          state_d = ST_INIT;
        end
      end
      ST_INIT: begin
        if (init_last) begin
          state_d = (len2_q == '0) ? ST_IDLE : ST_ROW;
        end
      end
      ST_ROW: begin
        if (len1_zero) begin
          if (row_last) begin
            state_d = ST_IDLE;
          end
        end else begin
          state_d = ST_CELL;
        end
      end
      ST_CELL: begin
        if (cell_last) begin
          state_d = row_last ? ST_IDLE : ST_ROW;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    finish    = 1'b0;
    t1_we     = 1'b0;
    t2_we     = 1'b0;
    sc_we     = 1'b0;
    sc_waddr  = cidx_q;
    sc_wdata  = left_q;
    row_re    = 1'b0;
    row_raddr = '0;
    t2_re     = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        t1_we = in_fire && (in_data_i.operation == OP_APPEND_FIRST) && !full1;
        t2_we = in_fire && (in_data_i.operation == OP_APPEND_SECOND) && !full2;
      end
      ST_INIT: begin
        sc_we  = !len1_zero;
        finish = init_last && (len2_q == '0);
      end
      ST_ROW: begin
        row_re = 1'b1;
        t2_re  = 1'b1;
        finish = len1_zero && row_last;
      end
      ST_CELL: begin
        sc_we     = 1'b1;
        sc_wdata  = cell_v;
        row_re    = 1'b1;
        row_raddr = cidx_q + AW'(1);
        finish    = cell_last && row_last;
      end
      default: ;
    endcase
  end

  // Datapath registers.
  always_comb begin
    len1_d      = len1_q;
    len2_d      = len2_q;
    trunc_d     = trunc_q;
    cidx_d      = cidx_q;
    xidx_d      = xidx_q;
    left_d      = left_q;
    diag_d      = diag_q;
    col_d       = col_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          case (op_e'(in_data_i.operation))
            OP_APPEND_FIRST: begin
              if (full1) begin
                trunc_d = 1'b1;
              end else begin
                len1_d = len1_q + LW'(1);
              end
            end
            OP_APPEND_SECOND: begin
              if (full2) begin
                trunc_d = 1'b1;
              end else begin
                len2_d = len2_q + LW'(1);
              end
            end
            OP_COMPUTE: begin
              cidx_d = '0;
              xidx_d = '0;
              left_d = SW'(STEP_EDGE);
              col_d  = '0;
              res_d  = '0;
            end
            default: ;
          endcase
        end
      end
      ST_INIT: begin
        if (!len1_zero) begin
          res_d  = left_q;
          left_d = left_q + SW'(STEP_EDGE);
          cidx_d = cidx_q + AW'(1);
        end
      end
      ST_ROW: begin
        diag_d = col_q;
        left_d = col_next;
        col_d  = col_next;
        cidx_d = '0;
        if (len1_zero) begin
          res_d  = col_next;
          xidx_d = xidx_q + AW'(1);
        end
      end
      ST_CELL: begin
        left_d = cell_v;
        diag_d = up;
        cidx_d = cidx_q + AW'(1);
        if (cell_last) begin
          res_d  = cell_v;
          xidx_d = xidx_q + AW'(1);
        end
      end
      default: ;
    endcase
    // Emit the result and clear both strings and the overflow flag.
    if (finish) begin
      out_valid_d    = 1'b1;
      out_d.distance = res_d[DIST_W-1:0];
      out_d.overflow = trunc_q;
      len1_d         = '0;
      len2_d         = '0;
      trunc_d        = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      len1_q      <= '0;
      len2_q      <= '0;
      trunc_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len1_q      <= len1_d;
      len2_q      <= len2_d;
      trunc_q     <= trunc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cidx_q <= cidx_d;
    xidx_q <= xidx_d;
    left_q <= left_d;
    diag_q <= diag_d;
    col_q  <= col_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  wed_ram #(
    .WIDTH(SYM_W),
    .DEPTH(MAX_LEN)
  ) u_first_text (
    .clk_i  (clk_i),
    .we_i   (t1_we),
    .waddr_i(len1_q[AW-1:0]),
    .wdata_i(in_data_i.symbol),
    .re_i   (row_re),
    .raddr_i(row_raddr),
    .rdata_o(c1)
  );

  wed_ram #(
    .WIDTH(SYM_W),
    .DEPTH(MAX_LEN)
  ) u_second_text (
    .clk_i  (clk_i),
    .we_i   (t2_we),
    .waddr_i(len2_q[AW-1:0]),
    .wdata_i(in_data_i.symbol),
    .re_i   (t2_re),
    .raddr_i(xidx_q),
    .rdata_o(c2)
  );

  // Score row, entry y-1 holds column y; column 0 lives in col_q.
  wed_ram #(
    .WIDTH(SW),
    .DEPTH(MAX_LEN)
  ) u_score_row (
    .clk_i  (clk_i),
    .we_i   (sc_we),
    .waddr_i(sc_waddr),
    .wdata_i(sc_wdata),
    .re_i   (row_re),
    .raddr_i(row_raddr),
    .rdata_o(up)
  );

`ifndef SYNTHESIS
  a_busy_no_request : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !in_ready_o)
    else $error("request taken while a compute is running");

  a_len_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (len1_q <= LW'(MAX_LEN)) && (len2_q <= LW'(MAX_LEN)))
    else $error("string length beyond store depth");

  a_cell_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CELL) |-> ((LW'(cidx_q) < len1_q) && (LW'(xidx_q) < len2_q)))
    else $error("cell walk outside the loaded strings");

  a_finish_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish |=> (len1_q == '0) && (len2_q == '0) && !trunc_q && out_valid_q)
    else $error("result emitted without clearing the strings");

  a_finish_slot_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish |-> !out_valid_q)
    else $error("result overwrites a pending result");
`endif

endmodule
